>>> rtl/smk_pkg.sv
// ----------------------------------------------------------------------------
// Smoke effect sequencer package
// Shared widths, constants, register indexes and word types of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package smk_pkg;

   localparam int DEFAULT_TIMER_WIDTH = 16;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int LEVEL_WIDTH         = 8;
   localparam int PHASE_WIDTH         = 3;
   localparam int TOGGLE_WIDTH        = 4;

   localparam logic [LEVEL_WIDTH-1:0]  LEVEL_START = 8'd10;
   localparam logic [LEVEL_WIDTH-1:0]  LEVEL_MAX   = 8'd255;
   localparam logic [TOGGLE_WIDTH-1:0] TOGGLE_LONG = 4'd9;

   // Reset values of the configuration registers.
   localparam logic [15:0] ARMED_MS_RESET     = 16'd6000;
   localparam logic [15:0] FLASH_MS_RESET     = 16'd200;
   localparam logic [15:0] FRAME_MS_RESET     = 16'd50;
   localparam logic [15:0] SMOKE_ON_RESET     = 16'd1000;
   localparam logic [15:0] SMOKE_SHORT_RESET  = 16'd1000;
   localparam logic [15:0] SMOKE_LONG_RESET   = 16'd5000;
   localparam logic [7:0]  RAMP_STEP_RESET    = 8'd5;
   localparam logic [15:0] SHUTDOWN_MS_RESET  = 16'd500;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ARMED_MS     = 3'd0,
      CSR_FLASH_MS     = 3'd1,
      CSR_FRAME_MS     = 3'd2,
      CSR_SMOKE_ON     = 3'd3,
      CSR_SMOKE_SHORT  = 3'd4,
      CSR_SMOKE_LONG   = 3'd5,
      CSR_RAMP_STEP    = 3'd6,
      CSR_SHUTDOWN_MS  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic button_level;
   } req_word_type;

   typedef struct packed {
      logic                   green_lamp;
      logic                   red_lamp;
      logic                   pump_drive;
      logic                   smoke_drive;
      logic                   frame_strobe;
      logic [LEVEL_WIDTH-1:0] fire_level;
      logic                   strip_clear;
      logic [PHASE_WIDTH-1:0] phase_now;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> rtl/smk_if.sv
// ----------------------------------------------------------------------------
// Smoke effect sequencer channels
// Valid/ready channels for the tick words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface smk_req_if;
   import smk_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface smk_rsp_if;
   import smk_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/smoke_effect_sequencer.sv
// ----------------------------------------------------------------------------
// Smoke effect sequencer
// Each input word is one 1 ms tick carrying the sampled, active-low button.
// The sequencer steps through idle, armed, warning, firing and shutdown and
// returns one result word per tick with the lamp, pump and smoke drives, the
// fire frame strobe and level, the strip clear flag and the current phase.
// The next state and the result word are formed by a few timer increments and
// compares in front of the state registers and the result register, so one word
// is accepted per clock as long as the result register is empty or is being
// read in the same cycle. A word therefore appears at the result channel in the
// cycle after it is accepted. Configuration registers are to be written by the
// user through the csr_ port only while no tick is in flight; the block itself
// does not enforce it. Timers are TIMER_WIDTH bits wide and saturate at their top value.
// ----------------------------------------------------------------------------
`default_nettype none

module smoke_effect_sequencer #(
   parameter int TIMER_WIDTH = smk_pkg::DEFAULT_TIMER_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   smk_req_if.sink                                   req_chan,
   smk_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_write_enable,
   input  wire logic [smk_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [smk_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import smk_pkg::*;

   // Compare width covers both the timers and the 16-bit limits.
   localparam int CMP_WIDTH = (TIMER_WIDTH > CSR_DATA_WIDTH) ? TIMER_WIDTH : CSR_DATA_WIDTH;
   localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = {TIMER_WIDTH{1'b1}};

   typedef enum logic [PHASE_WIDTH-1:0] {
      PH_IDLE  = 3'd0,
      PH_ARMED = 3'd1,
      PH_WARN  = 3'd2,
      PH_FIRE  = 3'd3,
      PH_SHUT  = 3'd4
   } phase_type;

   // Timers count up by one per tick and stick at their top value.
   function automatic logic [TIMER_WIDTH-1:0] timer_inc(input logic [TIMER_WIDTH-1:0] t);
      return (t == TIMER_TOP) ? t : t + 1'b1;
   endfunction

   // An interval ends on the tick the advanced timer reaches its limit.
   function automatic logic timer_done(input logic [TIMER_WIDTH-1:0]    t,
                                       input logic [CSR_DATA_WIDTH-1:0] lim);
      return CMP_WIDTH'(t) >= CMP_WIDTH'(lim);
   endfunction

   // Configuration registers.
   logic [15:0] armed_ms_ff;
   logic [15:0] flash_ms_ff;
   logic [15:0] frame_ms_ff;
   logic [15:0] smoke_on_ff;
   logic [15:0] smoke_short_ff;
   logic [15:0] smoke_long_ff;
   logic [7:0]  ramp_step_ff;
   logic [15:0] shutdown_ms_ff;

   // Sequencer state and its next values.
   phase_type               phase_ff,        phase_in;
   logic [TIMER_WIDTH-1:0]  phase_timer_ff,  phase_timer_in;
   logic [TIMER_WIDTH-1:0]  flash_timer_ff,  flash_timer_in;
   logic [TIMER_WIDTH-1:0]  frame_timer_ff,  frame_timer_in;
   logic [TIMER_WIDTH-1:0]  smoke_timer_ff,  smoke_timer_in;
   logic                    smoke_active_ff, smoke_active_in;
   logic [TOGGLE_WIDTH-1:0] toggle_count_ff, toggle_count_in;
   logic [LEVEL_WIDTH-1:0]  level_ff,        level_in;
   logic                    red_ff,          red_in;
   logic                    pump_ff,         pump_in;
   logic                    button_prev_ff,  button_prev_in;

   // Result register.
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic                  accept;
   logic                  lvl;
   logic                  press_edge;
   logic                  strobe;
   logic                  clear;
   logic [LEVEL_WIDTH-1:0] frame_level;
   logic [LEVEL_WIDTH:0]  level_sum;
   logic [15:0]           smoke_limit;

   // The result register is free when empty or when its word leaves now.
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign accept           = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   assign lvl        = req_chan.payload.button_level;
   assign press_edge = !lvl && button_prev_ff;
   assign level_sum  = {1'b0, level_ff} + {1'b0, ramp_step_ff};

   always_comb begin
      phase_in        = phase_ff;
      phase_timer_in  = phase_timer_ff;
      flash_timer_in  = flash_timer_ff;
      frame_timer_in  = frame_timer_ff;
      smoke_timer_in  = smoke_timer_ff;
      smoke_active_in = smoke_active_ff;
      toggle_count_in = toggle_count_ff;
      level_in        = level_ff;
      red_in          = red_ff;
      pump_in         = pump_ff;
      button_prev_in  = button_prev_ff;
      strobe          = 1'b0;
      clear           = 1'b0;
      frame_level     = '0;
      smoke_limit     = smoke_on_ff;

      case (phase_ff)
         PH_ARMED: begin
            button_prev_in = lvl;
            if (press_edge) begin
               // A second press cancels straight into shutdown.
               phase_in        = PH_SHUT;
               phase_timer_in  = '0;
               button_prev_in  = 1'b0;
               smoke_active_in = 1'b0;
               red_in          = 1'b1;
               pump_in         = 1'b1;
            end else begin
               phase_timer_in = timer_inc(phase_timer_ff);
               if (timer_done(phase_timer_in, armed_ms_ff)) begin
                  phase_in       = PH_WARN;
                  pump_in        = 1'b1;
                  phase_timer_in = '0;
                  flash_timer_in = '0;
               end
            end
         end
         PH_WARN: begin
            if (!lvl) begin
               phase_in        = PH_SHUT;
               phase_timer_in  = '0;
               button_prev_in  = 1'b0;
               smoke_active_in = 1'b0;
               red_in          = 1'b1;
               pump_in         = 1'b1;
            end else begin
               flash_timer_in = timer_inc(flash_timer_ff);
               if (timer_done(flash_timer_in, flash_ms_ff)) begin
                  red_in         = !red_ff;
                  flash_timer_in = '0;
               end
               phase_timer_in = timer_inc(phase_timer_ff);
               if (timer_done(phase_timer_in, armed_ms_ff)) begin
                  phase_in        = PH_FIRE;
                  red_in          = 1'b1;
                  frame_timer_in  = '0;
                  smoke_timer_in  = '0;
                  smoke_active_in = 1'b0;
                  toggle_count_in = '0;
                  level_in        = LEVEL_START;
               end
            end
         end
         PH_FIRE: begin
            if (!lvl) begin
               phase_in        = PH_SHUT;
               phase_timer_in  = '0;
               button_prev_in  = 1'b0;
               smoke_active_in = 1'b0;
               red_in          = 1'b1;
               pump_in         = 1'b1;
            end else begin
               frame_timer_in = timer_inc(frame_timer_ff);
               if (timer_done(frame_timer_in, frame_ms_ff)) begin
                  strobe         = 1'b1;
                  frame_level    = level_ff;
                  level_in       = level_sum[LEVEL_WIDTH] ? LEVEL_MAX
                                                          : level_sum[LEVEL_WIDTH-1:0];
                  frame_timer_in = '0;
               end
               // Off time turns long once the ninth toggle has been made.
               if (!smoke_active_ff) begin
                  smoke_limit = (toggle_count_ff >= TOGGLE_LONG) ? smoke_long_ff
                                                                 : smoke_short_ff;
               end
               smoke_timer_in = timer_inc(smoke_timer_ff);
               if (timer_done(smoke_timer_in, smoke_limit)) begin
                  smoke_active_in = !smoke_active_ff;
                  if (toggle_count_ff < TOGGLE_LONG) begin
                     toggle_count_in = toggle_count_ff + 1'b1;
                  end
                  smoke_timer_in = '0;
               end
            end
         end
         PH_SHUT: begin
            phase_timer_in = timer_inc(phase_timer_ff);
            if (timer_done(phase_timer_in, shutdown_ms_ff)) begin
               phase_in       = PH_IDLE;
               phase_timer_in = '0;
               pump_in        = 1'b0;
               red_in         = 1'b0;
               button_prev_in = 1'b0;
               clear          = 1'b1;
            end
         end
         default: begin
            // Idle, and any unknown phase code, behaves as idle.
            phase_in        = PH_IDLE;
            red_in          = 1'b0;
            pump_in         = 1'b0;
            smoke_active_in = 1'b0;
            button_prev_in  = lvl;
            if (press_edge) begin
               phase_in       = PH_ARMED;
               phase_timer_in = '0;
               red_in         = 1'b1;
               button_prev_in = 1'b0;
            end
         end
      endcase

      rsp_word_in.green_lamp   = (phase_in == PH_IDLE);
      rsp_word_in.red_lamp     = red_in;
      rsp_word_in.pump_drive   = pump_in;
      rsp_word_in.smoke_drive  = (phase_in == PH_FIRE) && smoke_active_in;
      rsp_word_in.frame_strobe = strobe;
      rsp_word_in.fire_level   = frame_level;
      rsp_word_in.strip_clear  = clear;
      rsp_word_in.phase_now    = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ms_ff     <= ARMED_MS_RESET;
         flash_ms_ff     <= FLASH_MS_RESET;
         frame_ms_ff     <= FRAME_MS_RESET;
         smoke_on_ff     <= SMOKE_ON_RESET;
         smoke_short_ff  <= SMOKE_SHORT_RESET;
         smoke_long_ff   <= SMOKE_LONG_RESET;
         ramp_step_ff    <= RAMP_STEP_RESET;
         shutdown_ms_ff  <= SHUTDOWN_MS_RESET;
         phase_ff        <= PH_IDLE;
         phase_timer_ff  <= '0;
         flash_timer_ff  <= '0;
         frame_timer_ff  <= '0;
         smoke_timer_ff  <= '0;
         smoke_active_ff <= 1'b0;
         toggle_count_ff <= '0;
         level_ff        <= LEVEL_START;
         red_ff          <= 1'b0;
         pump_ff         <= 1'b0;
         button_prev_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ARMED_MS:    armed_ms_ff    <= csr_write_data;
               CSR_FLASH_MS:    flash_ms_ff    <= csr_write_data;
               CSR_FRAME_MS:    frame_ms_ff    <= csr_write_data;
               CSR_SMOKE_ON:    smoke_on_ff    <= csr_write_data;
               CSR_SMOKE_SHORT: smoke_short_ff <= csr_write_data;
               CSR_SMOKE_LONG:  smoke_long_ff  <= csr_write_data;
               CSR_RAMP_STEP:   ramp_step_ff   <= csr_write_data[7:0];
               CSR_SHUTDOWN_MS: shutdown_ms_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff        <= phase_in;
            phase_timer_ff  <= phase_timer_in;
            flash_timer_ff  <= flash_timer_in;
            frame_timer_ff  <= frame_timer_in;
            smoke_timer_ff  <= smoke_timer_in;
            smoke_active_ff <= smoke_active_in;
            toggle_count_ff <= toggle_count_in;
            level_ff        <= level_in;
            red_ff          <= red_in;
            pump_ff         <= pump_in;
            button_prev_ff  <= button_prev_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // A held result word must block the next tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("tick accepted while result word is stalled");

   // The strip is only cleared on the return to idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.strip_clear |->
         rsp_word_ff.phase_now == PH_IDLE && rsp_word_ff.green_lamp)
      else $error("strip clear outside of return to idle");

   // Frames and smoke only come out while firing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.frame_strobe || rsp_word_ff.smoke_drive) |->
         rsp_word_ff.phase_now == PH_FIRE)
      else $error("fire output outside of firing phase");

   // The level ramp starts at ten and never drops below it.
   assert property (@(posedge clock) disable iff (reset)
      level_ff >= LEVEL_START)
      else $error("fire level below its start value");

   // The toggle count stops at its long-interval mark.
   assert property (@(posedge clock) disable iff (reset)
      toggle_count_ff <= TOGGLE_LONG)
      else $error("smoke toggle count past saturation");

endmodule

`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Smoke effect sequencer testbench
// Sends 1 ms tick words with a sampled button through the request channel and
// checks every result word against a predictor that runs alongside the block.
// Whole arm, warning, firing and shutdown sessions with random content are
// mixed with cancels and noise. The registers are reprogrammed between phases,
// and random gaps and stalls are placed on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import smk_pkg::*;

   localparam int TW        = DEFAULT_TIMER_WIDTH;
   localparam int LIMIT_NS  = 1_000_000;
   localparam int RANDOM_TICKS = 350;
   localparam int MAX_PRINTED  = 40;

   // Phase codes as they appear on phase_now.
   typedef enum logic [PHASE_WIDTH-1:0] {
      SEQ_IDLE     = 3'd0,
      SEQ_ARMED    = 3'd1,
      SEQ_WARN     = 3'd2,
      SEQ_FIRE     = 3'd3,
      SEQ_SHUTDOWN = 3'd4
   } seq_phase_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   smk_req_if req_if ();
   smk_rsp_if rsp_if ();

   smoke_effect_sequencer i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Tick words waiting to be sent, and the result words predicted for the
   // ticks the block has already taken, oldest first.
   req_word_type tick_queue [$];
   rsp_word_type predicted_words [$];

   int  ticks_sent;
   int  ticks_taken;
   int  words_seen;
   int  mismatch_count;
   int  send_wait;
   int  recv_wait;
   logic sender_calm;
   logic receiver_calm;

   // ------------------------------------------------------------------------
   // Predictor state: the sequencer's own registers plus its configuration.
   // ------------------------------------------------------------------------
   seq_phase_type              seq_phase;
   logic [TW-1:0]              phase_ticks;
   logic [TW-1:0]              flash_ticks;
   logic [TW-1:0]              frame_ticks;
   logic [TW-1:0]              smoke_ticks;
   logic                       smoke_on;
   logic [TOGGLE_WIDTH-1:0]    toggles;
   logic [LEVEL_WIDTH-1:0]     fire_lvl;
   logic                       red_on;
   logic                       pump_on;
   logic                       button_last;
   logic [CSR_DATA_WIDTH-1:0]  cfg [0:7];

   // Timers stop at their top value instead of wrapping.
   function automatic logic [TW-1:0] bump(input logic [TW-1:0] t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   // Every cancel goes through shutdown with the pump and red lamp on. The
   // button memory is cleared so a held button has to be released first.
   function automatic void begin_shutdown();
      seq_phase   = SEQ_SHUTDOWN;
      phase_ticks = '0;
      button_last = 1'b0;
      smoke_on    = 1'b0;
      red_on      = 1'b1;
      pump_on     = 1'b1;
   endfunction

   // Advances the predictor by one tick and returns the word the block
   // should produce for it.
   function automatic rsp_word_type advance_tick(input logic button);
      logic                   press;
      logic                   strobe;
      logic                   clear;
      logic [LEVEL_WIDTH-1:0] shown_lvl;
      logic [LEVEL_WIDTH:0]   next_lvl;
      logic [CSR_DATA_WIDTH-1:0] smoke_limit;
      rsp_word_type           word;
      press     = (button == 1'b0) && (button_last == 1'b1);
      strobe    = 1'b0;
      clear     = 1'b0;
      shown_lvl = '0;
      case (seq_phase)
         SEQ_ARMED: begin
            button_last = button;
            if (press) begin
               begin_shutdown();
            end else begin
               phase_ticks = bump(phase_ticks);
               if (phase_ticks >= cfg[CSR_ARMED_MS]) begin
                  seq_phase   = SEQ_WARN;
                  pump_on     = 1'b1;
                  phase_ticks = '0;
                  flash_ticks = '0;
               end
            end
         end
         SEQ_WARN: begin
            if (button == 1'b0) begin
               begin_shutdown();
            end else begin
               flash_ticks = bump(flash_ticks);
               if (flash_ticks >= cfg[CSR_FLASH_MS]) begin
                  red_on      = ~red_on;
                  flash_ticks = '0;
               end
               phase_ticks = bump(phase_ticks);
               if (phase_ticks >= cfg[CSR_ARMED_MS]) begin
                  seq_phase   = SEQ_FIRE;
                  red_on      = 1'b1;
                  frame_ticks = '0;
                  smoke_ticks = '0;
                  smoke_on    = 1'b0;
                  toggles     = '0;
                  fire_lvl    = LEVEL_START;
               end
            end
         end
         SEQ_FIRE: begin
            if (button == 1'b0) begin
               begin_shutdown();
            end else begin
               frame_ticks = bump(frame_ticks);
               if (frame_ticks >= cfg[CSR_FRAME_MS]) begin
                  next_lvl    = {1'b0, fire_lvl} + {1'b0, cfg[CSR_RAMP_STEP][LEVEL_WIDTH-1:0]};
                  strobe      = 1'b1;
                  shown_lvl   = fire_lvl;
                  fire_lvl    = (next_lvl > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                              : next_lvl[LEVEL_WIDTH-1:0];
                  frame_ticks = '0;
               end
               smoke_ticks = bump(smoke_ticks);
               if (smoke_on)
                  smoke_limit = cfg[CSR_SMOKE_ON];
               else if (toggles >= TOGGLE_LONG)
                  smoke_limit = cfg[CSR_SMOKE_LONG];
               else
                  smoke_limit = cfg[CSR_SMOKE_SHORT];
               if (smoke_ticks >= smoke_limit) begin
                  smoke_on = ~smoke_on;
                  if (toggles < TOGGLE_LONG)
                     toggles = toggles + 1'b1;
                  smoke_ticks = '0;
               end
            end
         end
         SEQ_SHUTDOWN: begin
            phase_ticks = bump(phase_ticks);
            if (phase_ticks >= cfg[CSR_SHUTDOWN_MS]) begin
               seq_phase   = SEQ_IDLE;
               phase_ticks = '0;
               pump_on     = 1'b0;
               red_on      = 1'b0;
               button_last = 1'b0;
               clear       = 1'b1;
            end
         end
         default: begin
            seq_phase   = SEQ_IDLE;
            red_on      = 1'b0;
            pump_on     = 1'b0;
            smoke_on    = 1'b0;
            button_last = button;
            if (press) begin
               seq_phase   = SEQ_ARMED;
               phase_ticks = '0;
               red_on      = 1'b1;
               button_last = 1'b0;
            end
         end
      endcase
      word.green_lamp   = (seq_phase == SEQ_IDLE);
      word.red_lamp     = red_on;
      word.pump_drive   = pump_on;
      word.smoke_drive  = (seq_phase == SEQ_FIRE) && smoke_on;
      word.frame_strobe = strobe;
      word.fire_level   = shown_lvl;
      word.strip_clear  = clear;
      word.phase_now    = seq_phase;
      return word;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   // Prints one line per failure, up to a cap, and counts every one.
   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("result word %0d: %s is %0d, expected %0d",
                                   words_seen, name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents tick words from tick_queue. The word on the channel is
   // handed to the predictor at the edge where the block takes it. After each
   // word a random gap is drawn, unless the sender is calm.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_ticks
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.payload <= '0;
         send_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted_words.push_back(advance_tick(req_if.payload.button_level));
            ticks_taken++;
         end
         // The channel is free when nothing is shown or the shown word
         // was just taken. Otherwise the word is held.
         if (!req_if.valid || req_if.ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_if.valid <= 1'b0;
            end else if (tick_queue.size() > 0) begin
               req_if.payload <= tick_queue.pop_front();
               req_if.valid   <= 1'b1;
               send_wait = sender_calm ? 0 : $urandom_range(0, 4);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: takes result words and compares each with the oldest
   // prediction. After each word the receiver may stall, unless it is calm.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : watch_results
      rsp_word_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (predicted_words.size() == 0) begin
               report_mismatch($sformatf("result word %0d arrived with none predicted",
                                         words_seen));
            end else begin
               want = predicted_words.pop_front();
               check_field("green_lamp", 8'(rsp_if.payload.green_lamp),
                           8'(want.green_lamp));
               check_field("red_lamp", 8'(rsp_if.payload.red_lamp), 8'(want.red_lamp));
               check_field("pump_drive", 8'(rsp_if.payload.pump_drive),
                           8'(want.pump_drive));
               check_field("smoke_drive", 8'(rsp_if.payload.smoke_drive),
                           8'(want.smoke_drive));
               check_field("frame_strobe", 8'(rsp_if.payload.frame_strobe),
                           8'(want.frame_strobe));
               check_field("fire_level", rsp_if.payload.fire_level, want.fire_level);
               check_field("strip_clear", 8'(rsp_if.payload.strip_clear),
                           8'(want.strip_clear));
               check_field("phase_now", 8'(rsp_if.payload.phase_now),
                           8'(want.phase_now));
            end
            words_seen++;
            recv_wait = receiver_calm ? 0 : $urandom_range(0, 4);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic push_ticks(input logic button, input int count);
      req_word_type word;
      word.button_level = button;
      for (int i = 0; i < count; i++)
         tick_queue.push_back(word);
      ticks_sent += count;
   endtask

   task automatic push_noise(input int count);
      for (int i = 0; i < count; i++)
         push_ticks(1'($urandom_range(0, 1)), 1);
   endtask

   // Waits until every queued tick has been taken and every predicted word
   // has come back. Then it lets the pipeline settle.
   task automatic drain();
      while (tick_queue.size() != 0 || ticks_taken != ticks_sent ||
             predicted_words.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // One register write per clock. The enable stays high across
   // back-to-back writes and is lowered only after the last one.
   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      cfg[idx] = (idx == CSR_RAMP_STEP) ? {8'd0, value[7:0]} : value;
   endtask

   task automatic program_profile(input logic [15:0] armed, input logic [15:0] flash,
                                  input logic [15:0] frame, input logic [15:0] on_time,
                                  input logic [15:0] short_off, input logic [15:0] long_off,
                                  input logic [7:0] ramp, input logic [15:0] shut);
      write_reg(CSR_ARMED_MS, armed);
      write_reg(CSR_FLASH_MS, flash);
      write_reg(CSR_FRAME_MS, frame);
      write_reg(CSR_SMOKE_ON, on_time);
      write_reg(CSR_SMOKE_SHORT, short_off);
      write_reg(CSR_SMOKE_LONG, long_off);
      write_reg(CSR_RAMP_STEP, {8'd0, ramp});
      write_reg(CSR_SHUTDOWN_MS, shut);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // A full arm sequence shaped by the current armed time. Most sessions
   // reach the firing phase. Some are cancelled by a press edge while armed,
   // by a press during the warning, or by a button held through the armed
   // time. Each session ends with random button levels during shutdown.
   task automatic push_session();
      int armed;
      int pick;
      armed = int'(cfg[CSR_ARMED_MS]);
      pick  = $urandom_range(0, 9);
      push_ticks(1'b1, $urandom_range(1, 3));
      push_ticks(1'b0, 1);
      case (pick)
         0: begin
            push_ticks(1'b1, $urandom_range(1, armed));
            push_ticks(1'b0, 1);
         end
         1: begin
            push_ticks(1'b1, armed + $urandom_range(0, armed));
            push_ticks(1'b0, 1);
         end
         2: begin
            push_ticks(1'b0, armed + 1);
         end
         default: begin
            push_ticks(1'b1, 2 * armed + $urandom_range(4, 50));
            push_ticks(1'b0, $urandom_range(1, 3));
         end
      endcase
      push_noise(int'(cfg[CSR_SHUTDOWN_MS]) + int'($urandom_range(0, 2)));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : run_test
      int random_start;
      logic [7:0] ramp;

      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_ARMED_MS;
      csr_write_data   <= '0;
      sender_calm      = 1'b0;
      receiver_calm    = 1'b0;

      // Predictor reset matches the block's reset state.
      seq_phase   = SEQ_IDLE;
      phase_ticks = '0;
      flash_ticks = '0;
      frame_ticks = '0;
      smoke_ticks = '0;
      smoke_on    = 1'b0;
      toggles     = '0;
      fire_lvl    = LEVEL_START;
      red_on      = 1'b0;
      pump_on     = 1'b0;
      button_last = 1'b0;
      cfg[CSR_ARMED_MS]    = ARMED_MS_RESET;
      cfg[CSR_FLASH_MS]    = FLASH_MS_RESET;
      cfg[CSR_FRAME_MS]    = FRAME_MS_RESET;
      cfg[CSR_SMOKE_ON]    = SMOKE_ON_RESET;
      cfg[CSR_SMOKE_SHORT] = SMOKE_SHORT_RESET;
      cfg[CSR_SMOKE_LONG]  = SMOKE_LONG_RESET;
      cfg[CSR_RAMP_STEP]   = {8'd0, RAMP_STEP_RESET};
      cfg[CSR_SHUTDOWN_MS] = SHUTDOWN_MS_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The times are short, the ramp step is at its top so
      // the level saturates on the second frame, and the shutdown time is
      // zero so shutdown ends on its first tick.
      program_profile(16'd3, 16'd1, 16'd1, 16'd1, 16'd2, 16'd3, 8'd255, 16'd0);
      push_ticks(1'b1, 1);   // release after reset
      push_ticks(1'b0, 1);   // press edge arms
      push_ticks(1'b1, 1);
      push_ticks(1'b0, 1);   // second press edge cancels while armed
      push_ticks(1'b0, 1);   // shutdown ends, strip is cleared
      push_ticks(1'b0, 1);   // held button is no press edge in idle
      push_ticks(1'b1, 1);
      push_ticks(1'b0, 1);   // arm
      push_ticks(1'b1, 3);   // armed time runs out, pump starts
      push_ticks(1'b1, 1);   // red lamp flashes every tick
      push_ticks(1'b0, 1);   // pressed button cancels the warning
      push_ticks(1'b1, 2);   // shutdown ends, then a release in idle
      push_ticks(1'b0, 4);   // arm, then held through the armed time
      push_ticks(1'b1, 3);   // warning runs out, firing starts
      push_ticks(1'b1, 8);   // a frame every tick, smoke toggling
      push_ticks(1'b0, 1);   // held button ends firing
      push_ticks(1'b1, 1);
      drain();

      // Top values. Here the armed time is ended by a cancel. The long
      // shutdown is still running when the next profile shortens it.
      program_profile(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      8'hFF, 16'hFFFF);
      push_ticks(1'b1, 1);
      push_ticks(1'b0, 1);
      push_ticks(1'b1, 2);
      push_ticks(1'b0, 1);
      push_noise(4);
      drain();

      // Long flash, frame and smoke times with a zero ramp step: the lamp
      // never toggles, no frame is emitted and the smoke stays off.
      program_profile(16'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      8'd0, 16'd1);
      push_session();
      push_session();
      drain();

      // Random part. Each phase draws short times so that sessions reach the
      // firing phase and the long smoke off time, and it draws the pacing of
      // both channels. The sender waits for every result at each boundary.
      random_start = ticks_sent;
      sender_calm   = 1'b1;
      receiver_calm = 1'b1;
      while (ticks_sent - random_start < RANDOM_TICKS) begin
         case ($urandom_range(0, 3))
            0: ramp = 8'd0;
            1: ramp = 8'd255;
            default: ramp = 8'($urandom_range(1, 254));
         endcase
         program_profile(16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
                         16'($urandom_range(1, 5)), 16'($urandom_range(1, 3)),
                         16'($urandom_range(1, 3)), 16'($urandom_range(1, 6)),
                         ramp, 16'($urandom_range(0, 5)));
         repeat ($urandom_range(2, 4)) begin
            if ($urandom_range(0, 3) == 0)
               push_noise($urandom_range(1, 8));
            push_session();
         end
         drain();
         sender_calm   = ($urandom_range(0, 3) == 0);
         receiver_calm = ($urandom_range(0, 3) == 0);
      end

      drain();
      repeat (5) @(posedge clock);
      if (predicted_words.size() != 0)
         report_mismatch($sformatf("%0d predicted words never arrived",
                                   predicted_words.size()));
      if (mismatch_count == 0)
         $display("PASS smoke_effect_sequencer");
      else
         $display("FAIL smoke_effect_sequencer");
      $finish;
   end

   // Ends a hung run.
   initial begin : watchdog
      #(LIMIT_NS);
      $display("FAIL smoke_effect_sequencer");
      $finish;
   end

endmodule
